// ===== src/kps_pkg.sv =====
// kps_pkg: shared types, phrase ROM and constants for the keyword phrase scanner.
// No dependencies; the matcher, tally, top level and bench use it.
`timescale 1ns / 1ps

package kps_pkg;

  localparam int unsigned NCrit     = 22;
  localparam int unsigned NHigh     = 12;
  localparam int unsigned NWarm     = 13;
  localparam int unsigned NAll      = NCrit + NHigh + NWarm;
  localparam int unsigned MaxChars  = 6;
  localparam int unsigned MaxBytes  = 3 * MaxChars;
  localparam int unsigned OutCntW   = 32;
  localparam int unsigned ThreshW   = 4;
  localparam logic [ThreshW-1:0] ThreshReset = 4'd2;

  typedef struct packed {
    logic [NWarm-1:0] warm;
    logic [NHigh-1:0] high;
    logic [NCrit-1:0] crit;
  } kps_hits_t;

  // finished text handed from the scan stage to the tally stage
  typedef struct packed {
    logic      valid;
    kps_hits_t hits;
  } kps_fin_t;

  typedef struct packed {
    logic [2:0]            chars;
    logic [MaxChars-1:0][15:0] cp;
  } phrase_t;

  function automatic phrase_t mk(input logic [2:0] n,
                                 input logic [15:0] c0, input logic [15:0] c1,
                                 input logic [15:0] c2, input logic [15:0] c3,
                                 input logic [15:0] c4, input logic [15:0] c5);
    phrase_t p;
    p.chars = n;
    p.cp[0] = c0;
    p.cp[1] = c1;
    p.cp[2] = c2;
    p.cp[3] = c3;
    p.cp[4] = c4;
    p.cp[5] = c5;
    return p;
  endfunction

  // critical 0..21, high 22..33, warmth 34..46
  function automatic phrase_t phrase_rom(input int unsigned idx);
    phrase_t p;
    unique case (idx)
      0:  p = mk(3'd4, 16'h6BEB, 16'h65E0, 16'h610F, 16'h4E49, 16'h0, 16'h0);
      1:  p = mk(3'd4, 16'h6CA1, 16'h6709, 16'h610F, 16'h4E49, 16'h0, 16'h0);
      2:  p = mk(3'd4, 16'h6BEB, 16'h65E0, 16'h4EF7, 16'h503C, 16'h0, 16'h0);
      3:  p = mk(3'd4, 16'h6CA1, 16'h6709, 16'h4EF7, 16'h503C, 16'h0, 16'h0);
      4:  p = mk(3'd3, 16'h4E0D, 16'h914D, 16'h6D3B, 16'h0, 16'h0, 16'h0);
      5:  p = mk(3'd4, 16'h4E0D, 16'h503C, 16'h5F97, 16'h6D3B, 16'h0, 16'h0);
      6:  p = mk(3'd2, 16'h5E9F, 16'h7269, 16'h0, 16'h0, 16'h0, 16'h0);
      7:  p = mk(3'd2, 16'h7D2F, 16'h8D58, 16'h0, 16'h0, 16'h0, 16'h0);
      8:  p = mk(3'd2, 16'h8D1F, 16'h62C5, 16'h0, 16'h0, 16'h0, 16'h0);
      9:  p = mk(3'd2, 16'h81EA, 16'h6740, 16'h0, 16'h0, 16'h0, 16'h0);
      10: p = mk(3'd2, 16'h81EA, 16'h6B8B, 16'h0, 16'h0, 16'h0, 16'h0);
      11: p = mk(3'd2, 16'h81EA, 16'h4F24, 16'h0, 16'h0, 16'h0, 16'h0);
      12: p = mk(3'd4, 16'h7ED3, 16'h675F, 16'h81EA, 16'h5DF1, 16'h0, 16'h0);
      13: p = mk(3'd2, 16'h4E86, 16'h7ED3, 16'h0, 16'h0, 16'h0, 16'h0);
      14: p = mk(3'd4, 16'h6BC1, 16'h706D, 16'h4E16, 16'h754C, 16'h0, 16'h0);
      15: p = mk(3'd4, 16'h6467, 16'h6BC1, 16'h4E00, 16'h5207, 16'h0, 16'h0);
      16: p = mk(3'd4, 16'h62A5, 16'h590D, 16'h793E, 16'h4F1A, 16'h0, 16'h0);
      17: p = mk(3'd6, 16'h4EBA, 16'h751F, 16'h6CA1, 16'h6709, 16'h610F, 16'h4E49);
      18: p = mk(3'd6, 16'h4E00, 16'h5207, 16'h90FD, 16'h662F, 16'h5047, 16'h7684);
      19: p = mk(3'd5, 16'h4E16, 16'h754C, 16'h662F, 16'h5047, 16'h7684, 16'h0);
      20: p = mk(3'd2, 16'h53BB, 16'h6B7B, 16'h0, 16'h0, 16'h0, 16'h0);
      21: p = mk(3'd3, 16'h6CA1, 16'h6551, 16'h4E86, 16'h0, 16'h0, 16'h0);
      22: p = mk(3'd5, 16'h6C38, 16'h8FDC, 16'h4E0D, 16'h53EF, 16'h80FD, 16'h0);
      23: p = mk(3'd4, 16'h6C38, 16'h8FDC, 16'h65E0, 16'h6CD5, 16'h0, 16'h0);
      24: p = mk(3'd5, 16'h7EDD, 16'h5BF9, 16'h4E0D, 16'h53EF, 16'h80FD, 16'h0);
      25: p = mk(3'd4, 16'h4E00, 16'h8F88, 16'h5B50, 16'h90FD, 16'h0, 16'h0);
      26: p = mk(3'd6, 16'h4EC0, 16'h4E48, 16'h4E5F, 16'h505A, 16'h4E0D, 16'h4E86);
      27: p = mk(3'd6, 16'h4EC0, 16'h4E48, 16'h90FD, 16'h505A, 16'h4E0D, 16'h4E86);
      28: p = mk(3'd3, 16'h6539, 16'h4E0D, 16'h4E86, 16'h0, 16'h0, 16'h0);
      29: p = mk(3'd4, 16'h4E60, 16'h60EF, 16'h5C31, 16'h597D, 16'h0, 16'h0);
      30: p = mk(3'd3, 16'h8BA4, 16'h547D, 16'h5427, 16'h0, 16'h0, 16'h0);
      31: p = mk(3'd2, 16'h77EB, 16'h60C5, 16'h0, 16'h0, 16'h0, 16'h0);
      32: p = mk(3'd3, 16'h73BB, 16'h7483, 16'h5FC3, 16'h0, 16'h0, 16'h0);
      33: p = mk(3'd3, 16'h60F3, 16'h592A, 16'h591A, 16'h0, 16'h0, 16'h0);
      34: p = mk(3'd2, 16'h6E29, 16'h6696, 16'h0, 16'h0, 16'h0, 16'h0);
      35: p = mk(3'd2, 16'h5E0C, 16'h671B, 16'h0, 16'h0, 16'h0, 16'h0);
      36: p = mk(3'd2, 16'h53EF, 16'h4EE5, 16'h0, 16'h0, 16'h0, 16'h0);
      37: p = mk(3'd2, 16'h80FD, 16'h591F, 16'h0, 16'h0, 16'h0, 16'h0);
      38: p = mk(3'd2, 16'h503C, 16'h5F97, 16'h0, 16'h0, 16'h0, 16'h0);
      39: p = mk(3'd2, 16'h966A, 16'h4F34, 16'h0, 16'h0, 16'h0, 16'h0);
      40: p = mk(3'd2, 16'h7406, 16'h89E3, 16'h0, 16'h0, 16'h0, 16'h0);
      41: p = mk(3'd1, 16'h7231, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      42: p = mk(3'd2, 16'h6210, 16'h957F, 16'h0, 16'h0, 16'h0, 16'h0);
      43: p = mk(3'd3, 16'h6162, 16'h6162, 16'h6765, 16'h0, 16'h0, 16'h0);
      44: p = mk(3'd3, 16'h6CA1, 16'h5173, 16'h7CFB, 16'h0, 16'h0, 16'h0);
      45: p = mk(3'd4, 16'h4E00, 16'h6B65, 16'h4E00, 16'h6B65, 16'h0, 16'h0);
      46: p = mk(3'd2, 16'h62E5, 16'h62B1, 16'h0, 16'h0, 16'h0, 16'h0);
      default: p = mk(3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    endcase
    return p;
  endfunction

  // byte k of the three-byte UTF-8 form of a phrase
  function automatic logic [7:0] phrase_byte(input phrase_t p, input int unsigned k);
    logic [15:0] cp;
    logic [7:0]  b;
    cp = p.cp[(k / 3) % MaxChars];
    unique case (k % 3)
      0:       b = {4'hE, cp[15:12]};
      1:       b = {2'b10, cp[11:6]};
      default: b = {2'b10, cp[5:0]};
    endcase
    return b;
  endfunction

endpackage

// ===== src/kps_in_if.sv =====
// kps_in_if: input channel of the phrase scanner, one text byte per word.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface kps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, output text_byte, output byte_present,
                  output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input byte_present,
                  input end_of_text, output ready);
endinterface

// ===== src/kps_out_if.sv =====
// kps_out_if: result channel of the phrase scanner, one verdict word per text.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface kps_out_if;
  logic        valid;
  logic        ready;
  logic        text_safe;
  logic [4:0]  crit_count;
  logic [3:0]  hi_count;
  logic [3:0]  warmth_count;
  logic [21:0] critical_mask;
  logic [11:0] high_mask;
  logic [12:0] warmth_mask;
  logic [31:0] texts_checked;
  logic [31:0] texts_blocked;

  modport source (output valid, output text_safe, output crit_count,
                  output hi_count, output warmth_count, output critical_mask,
                  output high_mask, output warmth_mask, output texts_checked,
                  output texts_blocked, input ready);
  modport sink   (input valid, input text_safe, input crit_count,
                  input hi_count, input warmth_count, input critical_mask,
                  input high_mask, input warmth_mask, input texts_checked,
                  input texts_blocked, output ready);
endinterface

// ===== src/kps_cell.sv =====
// kps_cell: one byte of the recent-byte window; takes its neighbour's byte on a shift.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module kps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (clear_i) begin
      byte_q <= 8'h00;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== src/kps_matcher.sv =====
// kps_matcher: compares every ROM phrase against the newest bytes of the window.
// Depends on kps_pkg for the phrase ROM and the hit struct.
`timescale 1ns / 1ps

module kps_matcher import kps_pkg::*; #(
  parameter int unsigned LONGEST_PHRASE_BYTES = 18
) (
  input  logic [LONGEST_PHRASE_BYTES-1:0][7:0] win_i,
  output kps_hits_t                            hits_o
);

  logic [NAll-1:0] hit;

  for (genvar g = 0; g < NAll; g++) begin : g_phrase
    localparam phrase_t     Ph   = phrase_rom(g);
    localparam int unsigned Len  = 3 * Ph.chars;
    localparam int unsigned Base = LONGEST_PHRASE_BYTES - Len;
    logic [MaxBytes-1:0] eq;
    for (genvar k = 0; k < MaxBytes; k++) begin : g_byte
      if (k < Len) begin : g_cmp
        assign eq[k] = (win_i[Base + k] == phrase_byte(Ph, k));
      end else begin : g_pad
        assign eq[k] = 1'b1;
      end
    end
    assign hit[g] = &eq;
  end

  assign hits_o.crit = hit[NCrit-1:0];
  assign hits_o.high = hit[NCrit+NHigh-1:NCrit];
  assign hits_o.warm = hit[NAll-1:NCrit+NHigh];

endmodule

// ===== src/kps_tally.sv =====
// kps_tally: counts hits of a finished text, judges it, keeps the totals and
// holds the result word. Depends on kps_pkg and kps_out_if.
`timescale 1ns / 1ps

module kps_tally import kps_pkg::*; #(
  parameter int unsigned TOTAL_COUNTER_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kps_fin_t           fin_i,
  input  logic [ThreshW-1:0] thresh_i,
  output logic               ready_o,
  kps_out_if.source          out_o
);

  localparam logic [TOTAL_COUNTER_BITS-1:0] CntMax = '1;

  logic                          out_valid_q;
  logic                          load;
  logic [4:0]                    n_crit;
  logic [3:0]                    n_high;
  logic [3:0]                    n_warm;
  logic                          safe;
  logic [TOTAL_COUNTER_BITS-1:0] checked_q, checked_d;
  logic [TOTAL_COUNTER_BITS-1:0] blocked_q, blocked_d;
  logic [TOTAL_COUNTER_BITS+OutCntW-1:0] checked_ext, blocked_ext;

  assign ready_o = !out_valid_q || out_o.ready;
  assign load    = fin_i.valid && ready_o;

  always_comb begin
    n_crit    = 5'($countones(fin_i.hits.crit));
    n_high    = 4'($countones(fin_i.hits.high));
    n_warm    = 4'($countones(fin_i.hits.warm));
    safe      = (n_crit == 5'd0) && (n_high < thresh_i);
    checked_d = (checked_q == CntMax) ? checked_q : checked_q + 1'b1;
    blocked_d = (safe || blocked_q == CntMax) ? blocked_q : blocked_q + 1'b1;
  end

  // low 32 bits, zero-extended for narrow totals
  assign checked_ext = {{OutCntW{1'b0}}, checked_d};
  assign blocked_ext = {{OutCntW{1'b0}}, blocked_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      checked_q   <= '0;
      blocked_q   <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      checked_q   <= checked_d;
      blocked_q   <= blocked_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.text_safe      <= safe;
      out_o.crit_count     <= n_crit;
      out_o.hi_count       <= n_high;
      out_o.warmth_count   <= n_warm;
      out_o.critical_mask  <= fin_i.hits.crit;
      out_o.high_mask      <= fin_i.hits.high;
      out_o.warmth_mask    <= fin_i.hits.warm;
      out_o.texts_checked  <= checked_ext[OutCntW-1:0];
      out_o.texts_blocked  <= blocked_ext[OutCntW-1:0];
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ===== src/keyword_phrase_scanner.sv =====
// Channel | dir | handshake    | word
// in_i    | in  | valid/ready  | text_byte, byte_present, end_of_text
// out_o   | out | valid/ready  | verdict, counts, masks, totals of one text
// cfg     | in  | cfg_we_i     | high_block_threshold (4 bits)
//
// One byte per cycle while in_i is ready; the window cells and all phrase compares
// work on the byte in the cycle it is taken. A text's result goes through the scan
// stage, then the tally register. Reset clears window, masks, totals and sets
// the threshold to 2. With the result register full and unread, one finished text
// waits in the scan stage; input stalls only on a further word after that.
// Top level of the keyword phrase scanner. Depends on kps_pkg, kps_in_if, kps_out_if,
// kps_cell, kps_matcher and kps_tally.
`timescale 1ns / 1ps

module keyword_phrase_scanner import kps_pkg::*; #(
  parameter int unsigned LONGEST_PHRASE_BYTES = 18,
  parameter int unsigned TOTAL_COUNTER_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ThreshW-1:0] cfg_wdata_i,
  kps_in_if.sink             in_i,
  kps_out_if.source          out_o
);

  localparam int unsigned WinLen = LONGEST_PHRASE_BYTES - 1;

  logic [ThreshW-1:0] thresh_q;
  logic               stopped_q;
  kps_hits_t          seen_q;
  kps_hits_t          seen_next;
  kps_hits_t          hits;
  kps_fin_t           fin_q;
  logic               tally_ready;
  logic               accept;
  logic               live;
  logic               scan;
  logic               last;
  logic [LONGEST_PHRASE_BYTES-1:0][7:0] win;

  assign in_i.ready = !fin_q.valid || tally_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign live       = accept && in_i.byte_present && !stopped_q;
  assign scan       = live && (in_i.text_byte != 8'h00);
  assign last       = accept && in_i.end_of_text;

  assign win[LONGEST_PHRASE_BYTES-1] = in_i.text_byte;

  for (genvar j = 0; j < WinLen; j++) begin : g_cell
    kps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (scan),
      .clear_i (last),
      .byte_i  (win[j+1]),
      .byte_o  (win[j])
    );
  end

  kps_matcher #(
    .LONGEST_PHRASE_BYTES (LONGEST_PHRASE_BYTES)
  ) u_matcher (
    .win_i  (win),
    .hits_o (hits)
  );

  assign seen_next = scan ? (seen_q | hits) : seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      stopped_q <= 1'b0;
      fin_q     <= '0;
    end else begin
      if (last) begin
        seen_q    <= '0;
        stopped_q <= 1'b0;
      end else if (accept) begin
        seen_q <= seen_next;
        // a zero byte ends matching for the rest of the text
        if (live && !scan) begin
          stopped_q <= 1'b1;
        end
      end
      if (last) begin
        fin_q.valid <= 1'b1;
        fin_q.hits  <= seen_next;
      end else if (tally_ready) begin
        fin_q.valid <= 1'b0;
      end
    end
  end

  kps_tally #(
    .TOTAL_COUNTER_BITS (TOTAL_COUNTER_BITS)
  ) u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fin_i    (fin_q),
    .thresh_i (thresh_q),
    .ready_o  (tally_ready),
    .out_o    (out_o)
  );

endmodule

// ===== src/kps_checker.sv =====
// kps_checker: port-level checks on the scanner's result channel, bound to the top.
// Depends on keyword_phrase_scanner's ports only.
`timescale 1ns / 1ps

module kps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        text_safe_i,
  input logic [4:0]  crit_count_i,
  input logic [3:0]  hi_count_i,
  input logic [3:0]  warmth_count_i,
  input logic [21:0] critical_mask_i,
  input logic [11:0] high_mask_i,
  input logic [12:0] warmth_mask_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(critical_mask_i)
      && $stable(high_mask_i) && $stable(warmth_mask_i) && $stable(text_safe_i))
    else $error("result word changed while stalled");

  a_safe_crit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && text_safe_i |-> crit_count_i == 5'd0)
    else $error("safe verdict with critical hits");

  a_crit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> crit_count_i == 5'($countones(critical_mask_i)))
    else $error("critical count does not match mask");

  a_hw_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> hi_count_i == 4'($countones(high_mask_i))
      && warmth_count_i == 4'($countones(warmth_mask_i)))
    else $error("high or warmth count does not match mask");

endmodule

bind keyword_phrase_scanner kps_checker u_kps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .text_safe_i      (out_o.text_safe),
  .crit_count_i     (out_o.crit_count),
  .hi_count_i       (out_o.hi_count),
  .warmth_count_i   (out_o.warmth_count),
  .critical_mask_i  (out_o.critical_mask),
  .high_mask_i      (out_o.high_mask),
  .warmth_mask_i    (out_o.warmth_mask)
);

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for keyword_phrase_scanner; feeds byte streams of phrase-laden
// texts and checks every verdict word against a scoreboard with its own phrase matcher.
// Depends on kps_pkg, kps_in_if, kps_out_if and the scanner RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic                       safe;
  logic [4:0]                 crit_cnt;
  logic [3:0]                 high_cnt;
  logic [3:0]                 warm_cnt;
  logic [kps_pkg::NCrit-1:0]  crit_mask;
  logic [kps_pkg::NHigh-1:0]  high_mask;
  logic [kps_pkg::NWarm-1:0]  warm_mask;
  logic [31:0]                checked;
  logic [31:0]                blocked;
} verdict_t;

// {character count, code points first to last}, critical then high then warmth
function automatic logic [98:0] rom_entry(input int idx);
  logic [98:0] e;
  case (idx)
    0:  e = {3'd4, 96'h6BEB_65E0_610F_4E49_0000_0000};
    1:  e = {3'd4, 96'h6CA1_6709_610F_4E49_0000_0000};
    2:  e = {3'd4, 96'h6BEB_65E0_4EF7_503C_0000_0000};
    3:  e = {3'd4, 96'h6CA1_6709_4EF7_503C_0000_0000};
    4:  e = {3'd3, 96'h4E0D_914D_6D3B_0000_0000_0000};
    5:  e = {3'd4, 96'h4E0D_503C_5F97_6D3B_0000_0000};
    6:  e = {3'd2, 96'h5E9F_7269_0000_0000_0000_0000};
    7:  e = {3'd2, 96'h7D2F_8D58_0000_0000_0000_0000};
    8:  e = {3'd2, 96'h8D1F_62C5_0000_0000_0000_0000};
    9:  e = {3'd2, 96'h81EA_6740_0000_0000_0000_0000};
    10: e = {3'd2, 96'h81EA_6B8B_0000_0000_0000_0000};
    11: e = {3'd2, 96'h81EA_4F24_0000_0000_0000_0000};
    12: e = {3'd4, 96'h7ED3_675F_81EA_5DF1_0000_0000};
    13: e = {3'd2, 96'h4E86_7ED3_0000_0000_0000_0000};
    14: e = {3'd4, 96'h6BC1_706D_4E16_754C_0000_0000};
    15: e = {3'd4, 96'h6467_6BC1_4E00_5207_0000_0000};
    16: e = {3'd4, 96'h62A5_590D_793E_4F1A_0000_0000};
    17: e = {3'd6, 96'h4EBA_751F_6CA1_6709_610F_4E49};
    18: e = {3'd6, 96'h4E00_5207_90FD_662F_5047_7684};
    19: e = {3'd5, 96'h4E16_754C_662F_5047_7684_0000};
    20: e = {3'd2, 96'h53BB_6B7B_0000_0000_0000_0000};
    21: e = {3'd3, 96'h6CA1_6551_4E86_0000_0000_0000};
    22: e = {3'd5, 96'h6C38_8FDC_4E0D_53EF_80FD_0000};
    23: e = {3'd4, 96'h6C38_8FDC_65E0_6CD5_0000_0000};
    24: e = {3'd5, 96'h7EDD_5BF9_4E0D_53EF_80FD_0000};
    25: e = {3'd4, 96'h4E00_8F88_5B50_90FD_0000_0000};
    26: e = {3'd6, 96'h4EC0_4E48_4E5F_505A_4E0D_4E86};
    27: e = {3'd6, 96'h4EC0_4E48_90FD_505A_4E0D_4E86};
    28: e = {3'd3, 96'h6539_4E0D_4E86_0000_0000_0000};
    29: e = {3'd4, 96'h4E60_60EF_5C31_597D_0000_0000};
    30: e = {3'd3, 96'h8BA4_547D_5427_0000_0000_0000};
    31: e = {3'd2, 96'h77EB_60C5_0000_0000_0000_0000};
    32: e = {3'd3, 96'h73BB_7483_5FC3_0000_0000_0000};
    33: e = {3'd3, 96'h60F3_592A_591A_0000_0000_0000};
    34: e = {3'd2, 96'h6E29_6696_0000_0000_0000_0000};
    35: e = {3'd2, 96'h5E0C_671B_0000_0000_0000_0000};
    36: e = {3'd2, 96'h53EF_4EE5_0000_0000_0000_0000};
    37: e = {3'd2, 96'h80FD_591F_0000_0000_0000_0000};
    38: e = {3'd2, 96'h503C_5F97_0000_0000_0000_0000};
    39: e = {3'd2, 96'h966A_4F34_0000_0000_0000_0000};
    40: e = {3'd2, 96'h7406_89E3_0000_0000_0000_0000};
    41: e = {3'd1, 96'h7231_0000_0000_0000_0000_0000};
    42: e = {3'd2, 96'h6210_957F_0000_0000_0000_0000};
    43: e = {3'd3, 96'h6162_6162_6765_0000_0000_0000};
    44: e = {3'd3, 96'h6CA1_5173_7CFB_0000_0000_0000};
    45: e = {3'd4, 96'h4E00_6B65_4E00_6B65_0000_0000};
    46: e = {3'd2, 96'h62E5_62B1_0000_0000_0000_0000};
    default: e = '0;
  endcase
  return e;
endfunction

function automatic int rom_len(input int idx);
  logic [98:0] e;
  e = rom_entry(idx);
  return 3 * int'(e[98:96]);
endfunction

// byte k of the phrase in three-byte UTF-8
function automatic logic [7:0] rom_byte(input int idx, input int k);
  logic [98:0] e;
  logic [15:0] cp;
  e = rom_entry(idx);
  cp = e[95 - 16 * (k / 3) -: 16];
  case (k % 3)
    0:       return {4'hE, cp[15:12]};
    1:       return {2'b10, cp[11:6]};
    default: return {2'b10, cp[5:0]};
  endcase
endfunction

class verdict_board;
  localparam int WinLen = 17;
  localparam int NAll = kps_pkg::NCrit + kps_pkg::NHigh + kps_pkg::NWarm;

  logic [3:0]                threshold;
  logic [7:0]                recent [WinLen];
  logic [kps_pkg::NCrit-1:0] crit_seen;
  logic [kps_pkg::NHigh-1:0] high_seen;
  logic [kps_pkg::NWarm-1:0] warm_seen;
  bit                        zero_stop;
  logic [31:0]               checked_total;
  logic [31:0]               blocked_sum;
  verdict_t                  pending_verdicts [$];
  int                        errors;

  function new();
    threshold = kps_pkg::ThreshReset;
    checked_total = '0;
    blocked_sum = '0;
    errors = 0;
    clear_text();
  endfunction

  function void clear_text();
    foreach (recent[i]) recent[i] = 8'h00;
    crit_seen = '0;
    high_seen = '0;
    warm_seen = '0;
    zero_stop = 1'b0;
  endfunction

  function void scan_byte(logic [7:0] b);
    logic [7:0] win [WinLen + 1];
    int len;
    bit hit;
    for (int i = 0; i < WinLen; i++) win[i] = recent[i];
    win[WinLen] = b;
    for (int p = 0; p < NAll; p++) begin
      len = rom_len(p);
      hit = 1'b1;
      for (int k = 0; k < len; k++)
        if (win[WinLen + 1 - len + k] != rom_byte(p, k)) hit = 1'b0;
      if (hit) begin
        if (p < kps_pkg::NCrit) crit_seen[p] = 1'b1;
        else if (p < kps_pkg::NCrit + kps_pkg::NHigh) high_seen[p - kps_pkg::NCrit] = 1'b1;
        else warm_seen[p - kps_pkg::NCrit - kps_pkg::NHigh] = 1'b1;
      end
    end
    for (int i = 0; i < WinLen; i++) recent[i] = win[i + 1];
  endfunction

  // called for every accepted input word
  function void take_word(logic [7:0] b, logic present, logic eot);
    verdict_t v;
    if (present && !zero_stop) begin
      if (b == 8'h00) zero_stop = 1'b1;
      else scan_byte(b);
    end
    if (eot) begin
      v.crit_cnt  = 5'($countones(crit_seen));
      v.high_cnt  = 4'($countones(high_seen));
      v.warm_cnt  = 4'($countones(warm_seen));
      v.safe      = (v.crit_cnt == 0) && (v.high_cnt < threshold);
      v.crit_mask = crit_seen;
      v.high_mask = high_seen;
      v.warm_mask = warm_seen;
      if (checked_total != '1) checked_total++;
      if (!v.safe && blocked_sum != '1) blocked_sum++;
      v.checked = checked_total;
      v.blocked = blocked_sum;
      pending_verdicts.push_back(v);
      clear_text();
    end
  endfunction

  function void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_verdict(verdict_t got);
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $error("verdict word with none outstanding");
      errors++;
      return;
    end
    want = pending_verdicts.pop_front();
    match_field("text_safe", 32'(want.safe), 32'(got.safe));
    match_field("crit_count", 32'(want.crit_cnt), 32'(got.crit_cnt));
    match_field("hi_count", 32'(want.high_cnt), 32'(got.high_cnt));
    match_field("warmth_count", 32'(want.warm_cnt), 32'(got.warm_cnt));
    match_field("critical_mask", 32'(want.crit_mask), 32'(got.crit_mask));
    match_field("high_mask", 32'(want.high_mask), 32'(got.high_mask));
    match_field("warmth_mask", 32'(want.warm_mask), 32'(got.warm_mask));
    match_field("texts_checked", want.checked, got.checked);
    match_field("texts_blocked", want.blocked, got.blocked);
  endfunction
endclass

module tb;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 120;
  localparam int LoveIdx = 41;
  localparam int WarmthIdx = 34;
  localparam int GoDieIdx = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  kps_in_if  text_if ();
  kps_out_if verdict_if ();

  keyword_phrase_scanner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (text_if),
    .out_o       (verdict_if)
  );

  verdict_board board;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_req;
  int           cycle_count;
  logic [7:0]   text_q [$];

  always #1 clk_i = ~clk_i;

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    verdict_t got;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    verdict_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && verdict_if.valid && verdict_if.ready) begin
        got.safe      = verdict_if.text_safe;
        got.crit_cnt  = verdict_if.crit_count;
        got.high_cnt  = verdict_if.hi_count;
        got.warm_cnt  = verdict_if.warmth_count;
        got.crit_mask = verdict_if.critical_mask;
        got.high_mask = verdict_if.high_mask;
        got.warm_mask = verdict_if.warmth_mask;
        got.checked   = verdict_if.texts_checked;
        got.blocked   = verdict_if.texts_blocked;
        board.check_verdict(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_if.ready <= 1'b0;
      end else begin
        verdict_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic push_word(input logic [7:0] b, input logic present, input logic eot);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid        <= 1'b1;
    text_if.text_byte    <= b;
    text_if.byte_present <= present;
    text_if.end_of_text  <= eot;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    board.take_word(b, present, eot);
  endtask

  task automatic wait_idle();
    text_if.valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.threshold = v;
  endtask

  // whole phrases, cut-off phrases, stray CJK characters, odd bytes, now and then a zero
  function automatic void build_text(input int segs);
    int kind;
    int idx;
    int len;
    int cut;
    text_q.delete();
    repeat (segs) begin
      kind = $urandom_range(99);
      idx  = $urandom_range(46);
      len  = rom_len(idx);
      if (kind < 50) begin
        for (int k = 0; k < len; k++) text_q.push_back(rom_byte(idx, k));
      end else if (kind < 65) begin
        cut = $urandom_range(len - 1, 1);
        for (int k = 0; k < cut; k++) text_q.push_back(rom_byte(idx, k));
      end else if (kind < 82) begin
        text_q.push_back(8'hE4 + 8'($urandom_range(5)));
        text_q.push_back({2'b10, 6'($urandom)});
        text_q.push_back({2'b10, 6'($urandom)});
      end else if (kind < 97) begin
        text_q.push_back(8'($urandom_range(255, 1)));
      end else begin
        text_q.push_back(8'h00);
      end
    end
  endfunction

  task automatic send_text(inout int sent);
    int  n;
    bit  close_apart;
    n = text_q.size();
    close_apart = (n == 0) || ($urandom_range(4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(text_q[i], 1'b1, !close_apart && i == n - 1);
      sent++;
    end
    if (close_apart) begin
      push_word(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  task automatic run_phase(input logic [3:0] thr, input int s_pct, input int r_pct,
                           input int items, input int segs_max, input bit squeeze);
    int sent;
    sent = 0;
    wait_idle();
    write_threshold(thr);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    if (squeeze) hold_req++;
    while (sent < items) begin
      build_text($urandom_range(segs_max));
      send_text(sent);
    end
  endtask

  initial begin
    int sent;
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    sent           = 0;
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    text_if.valid        <= 1'b0;
    text_if.text_byte    <= '0;
    text_if.byte_present <= 1'b0;
    text_if.end_of_text  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty text, byte extremes, a lone no-byte word, matching cut short
    // by a zero byte, and a phrase completed on the closing word
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'h01, 1'b1, 1'b0);
    push_word(8'h7F, 1'b1, 1'b1);
    push_word(8'hAA, 1'b0, 1'b0);
    for (int k = 0; k < 3; k++) push_word(rom_byte(LoveIdx, k), 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    for (int k = 0; k < 6; k++) push_word(rom_byte(WarmthIdx, k), 1'b1, k == 5);
    for (int k = 0; k < 6; k++) push_word(rom_byte(GoDieIdx, k), 1'b1, k == 5);

    run_phase(4'd1, 0, 0, 40, 4, 1'b0);
    run_phase(4'd13, 75, 0, 40, 4, 1'b0);
    // every high phrase in one text: count reaches its top against a threshold of 13
    text_q.delete();
    for (int p = kps_pkg::NCrit; p < kps_pkg::NCrit + kps_pkg::NHigh; p++)
      for (int k = 0; k < rom_len(p); k++) text_q.push_back(rom_byte(p, k));
    send_text(sent);
    run_phase(4'd0, 0, 75, 40, 4, 1'b0);
    run_phase(4'd15, 35, 35, 40, 4, 1'b0);
    run_phase(4'($urandom_range(13, 1)), 0, 0, 40, 1, 1'b1);
    run_phase(4'd2, 35, 35, 40, 4, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/kps_pkg.sv
src/kps_in_if.sv
src/kps_out_if.sv
src/kps_cell.sv
src/kps_matcher.sv
src/kps_tally.sv
src/keyword_phrase_scanner.sv
src/kps_checker.sv
tb/sv/tb.sv
